@@ hw/rtl/signed_int_to_decimal_ascii_unit_defines.svh @@
// assertion macros for the signed integer to decimal ascii unit
// depends on nothing; the asserting files include it by bare name
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// clocked check with explicit clock and reset
`define SIDAS_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check on the block clock and reset
`define SIDAS_ASSERT(lbl, prop, msg) \
   `SIDAS_ASSERT_CLK(lbl, clock, reset, prop, msg)
`else
`define SIDAS_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define SIDAS_ASSERT(lbl, prop, msg)
`endif
`endif

@@ hw/rtl/sidas_pkg.sv @@
// shared types and constants of the signed integer to decimal ascii unit
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package sidas_pkg;
   localparam int VALUE_BITS = 32;
   // decimal digits of the largest magnitude, 2**(VALUE_BITS-1)
   localparam int DIGITS     = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
   localparam int BCD_BITS   = 4 * DIGITS;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);
   localparam int DIG_BITS   = $clog2(DIGITS + 1);

   localparam int DIGIT_BASE = 10;
   localparam logic [3:0] ADJ_THRESH = 4'(DIGIT_BASE / 2);
   localparam logic [3:0] ADJ_ADD    = 4'((16 - DIGIT_BASE) / 2);
   localparam logic [3:0] DIGIT_MAX  = 4'(DIGIT_BASE - 1);

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(VALUE_BITS - 1);
   localparam logic [CNT_BITS-1:0] CNT_ZERO = CNT_BITS'(0);
   localparam logic [DIG_BITS-1:0] DIG_FULL = DIG_BITS'(DIGITS);
   localparam logic [DIG_BITS-1:0] DIG_ONE  = DIG_BITS'(1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONVERT,
      S_STRIP,
      S_SIGN,
      S_DIGITS
   } state_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } char_type;
endpackage
`default_nettype wire

@@ hw/rtl/sidas_dabble_step.sv @@
// one shift-add-3 step of the binary to bcd conversion
// depends on sidas_pkg
`timescale 1ns / 1ps
`default_nettype none
module sidas_dabble_step (
   input  wire logic [sidas_pkg::BCD_BITS-1:0] bcd_cur,
   input  wire logic                           shift_bit,
   output logic      [sidas_pkg::BCD_BITS-1:0] bcd_next
);
   logic [sidas_pkg::BCD_BITS-1:0] bcd_adj;

   // every digit of five or more gets three so the shift carries into the next
   always_comb begin
      for (int d = 0; d < sidas_pkg::DIGITS; d++) begin
         if (bcd_cur[4*d +: 4] >= sidas_pkg::ADJ_THRESH) begin
            bcd_adj[4*d +: 4] = bcd_cur[4*d +: 4] + sidas_pkg::ADJ_ADD;
         end else begin
            bcd_adj[4*d +: 4] = bcd_cur[4*d +: 4];
         end
      end
   end

   assign bcd_next = {bcd_adj[sidas_pkg::BCD_BITS-2:0], shift_bit};
endmodule
`default_nettype wire

@@ hw/rtl/sidas_out_reg.sv @@
// result register between the sequencer and the rsp channel
// depends on sidas_pkg
`timescale 1ns / 1ps
`default_nettype none
module sidas_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire sidas_pkg::char_type push_data,
   output logic                    push_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [7:0]              rsp_char_code,
   output logic                    rsp_last_char
);
   logic                valid_ff;
   logic                valid_in;
   sidas_pkg::char_type data_ff;

   // free when empty or when the held transaction leaves this cycle
   assign push_ready = !valid_ff || !rsp_stall;
   assign valid_in   = push_valid ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = data_ff.char_code;
   assign rsp_last_char = data_ff.last_char;
endmodule
`default_nettype wire

@@ hw/rtl/signed_int_to_decimal_ascii_unit.sv @@
// top level: signed integer to decimal ascii text, one character per transaction
// depends on sidas_pkg, sidas_dabble_step, sidas_out_reg and the defines header
//
//   channel | direction | payload                       | handshake
//   req     | in        | req_value (32 bits, signed)   | req_valid / req_stall
//   rsp     | out       | rsp_char_code, rsp_last_char  | rsp_valid / rsp_stall
//
// a load, then one shift-add-3 step per magnitude bit on the shared dabble unit, then
// one strip step per leading zero plus one, then one character per transaction; zeros
// dropped plus digits printed make ten, and a negative number sends a minus sign first
// req_stall is low only in idle, where a number is loaded, and high until the last
// character enters the output register; rsp_stall holds it and pauses the sequencer
// synchronous active-high reset returns to idle and empties the output register
`timescale 1ns / 1ps
`default_nettype none
`include "signed_int_to_decimal_ascii_unit_defines.svh"
module signed_int_to_decimal_ascii_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [sidas_pkg::VALUE_BITS-1:0] req_value,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [7:0]                                  rsp_char_code,
   output logic                                        rsp_last_char
);
   // sequencer state
   sidas_pkg::state_type state_ff;
   sidas_pkg::state_type state_in;

   // datapath: binary magnitude shifts out its msb into the bcd register
   logic [sidas_pkg::VALUE_BITS-1:0] bin_ff;
   logic [sidas_pkg::BCD_BITS-1:0]   bcd_ff;
   logic                             neg_ff;
   logic [sidas_pkg::CNT_BITS-1:0]   cnt_ff;
   logic [sidas_pkg::DIG_BITS-1:0]   dig_ff;

   logic [sidas_pkg::VALUE_BITS-1:0] mag_in;
   logic [sidas_pkg::BCD_BITS-1:0]   bcd_step;
   logic [3:0]                       dig_top;
   logic                             lead_zero;

   // control outputs of the sequencer
   logic                load_en;
   logic                step_en;
   logic                drop_en;
   logic                push_valid;
   logic                push_ready;
   logic                push_digit;
   sidas_pkg::char_type push_data;

   // two's complement magnitude; the most negative value maps to 2**(n-1)
   assign mag_in = req_value[sidas_pkg::VALUE_BITS-1]
                 ? ((~req_value) + {{(sidas_pkg::VALUE_BITS-1){1'b0}}, 1'b1})
                 : req_value;

   // top digit still to print and whether it is a leading zero to drop
   assign dig_top   = bcd_ff[sidas_pkg::BCD_BITS-1 -: 4];
   assign lead_zero = (dig_top == 4'd0) && (dig_ff != sidas_pkg::DIG_ONE);

   sidas_dabble_step u_step (
      .bcd_cur   (bcd_ff),
      .shift_bit (bin_ff[sidas_pkg::VALUE_BITS-1]),
      .bcd_next  (bcd_step)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sidas_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = sidas_pkg::S_CONVERT;
            end
         end
         sidas_pkg::S_CONVERT: begin
            if (cnt_ff == sidas_pkg::CNT_ZERO) begin
               state_in = sidas_pkg::S_STRIP;
            end
         end
         sidas_pkg::S_STRIP: begin
            if (!lead_zero) begin
               state_in = neg_ff ? sidas_pkg::S_SIGN : sidas_pkg::S_DIGITS;
            end
         end
         sidas_pkg::S_SIGN: begin
            if (push_ready) begin
               state_in = sidas_pkg::S_DIGITS;
            end
         end
         sidas_pkg::S_DIGITS: begin
            if (push_ready && (dig_ff == sidas_pkg::DIG_ONE)) begin
               state_in = sidas_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sidas_pkg::S_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      load_en    = 1'b0;
      step_en    = 1'b0;
      drop_en    = 1'b0;
      push_valid = 1'b0;
      push_digit = 1'b0;
      req_stall  = 1'b1;
      push_data  = '{char_code: sidas_pkg::CHAR_MINUS, last_char: 1'b0};
      case (state_ff)
         sidas_pkg::S_IDLE: begin
            req_stall = 1'b0;
            load_en   = req_valid;
         end
         sidas_pkg::S_CONVERT: begin
            step_en = 1'b1;
         end
         sidas_pkg::S_STRIP: begin
            drop_en = lead_zero;
         end
         sidas_pkg::S_SIGN: begin
            push_valid = 1'b1;
         end
         sidas_pkg::S_DIGITS: begin
            push_valid = 1'b1;
            push_digit = push_ready;
            push_data  = '{char_code: sidas_pkg::CHAR_ZERO + {4'd0, dig_top},
                           last_char: (dig_ff == sidas_pkg::DIG_ONE)};
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sidas_pkg::S_IDLE;
         cnt_ff   <= sidas_pkg::CNT_ZERO;
         dig_ff   <= sidas_pkg::DIG_FULL;
      end else begin
         state_ff <= state_in;
         if (load_en) begin
            cnt_ff <= sidas_pkg::CNT_LAST;
            dig_ff <= sidas_pkg::DIG_FULL;
         end else begin
            if (step_en && (cnt_ff != sidas_pkg::CNT_ZERO)) begin
               cnt_ff <= cnt_ff - sidas_pkg::CNT_BITS'(1);
            end
            if (drop_en || push_digit) begin
               dig_ff <= dig_ff - sidas_pkg::DIG_ONE;
            end
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (load_en) begin
         bin_ff <= mag_in;
         bcd_ff <= '0;
         neg_ff <= req_value[sidas_pkg::VALUE_BITS-1];
      end else if (step_en) begin
         bin_ff <= {bin_ff[sidas_pkg::VALUE_BITS-2:0], 1'b0};
         bcd_ff <= bcd_step;
      end else if (drop_en || push_digit) begin
         // move the next digit into the top position
         bcd_ff <= {bcd_ff[sidas_pkg::BCD_BITS-5:0], 4'd0};
      end
   end

   sidas_out_reg u_out (
      .clock         (clock),
      .reset         (reset),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .push_ready    (push_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   // an accepted transaction starts the conversion on the next cycle
   `SIDAS_ASSERT(a_accept_converts, (req_valid && !req_stall) |=> (state_ff == sidas_pkg::S_CONVERT), "accept did not start conversion")
   // a printed digit is always a decimal digit
   `SIDAS_ASSERT(a_digit_range, (state_ff == sidas_pkg::S_DIGITS) |-> (dig_top <= sidas_pkg::DIGIT_MAX), "bcd digit out of range")
   // at least one digit remains whenever digits are being printed
   `SIDAS_ASSERT(a_digits_left, (state_ff == sidas_pkg::S_DIGITS) |-> (dig_ff != '0), "digit count ran out")
   // a minus sign never ends a run
   `SIDAS_ASSERT(a_minus_not_last, (rsp_valid && (rsp_char_code == sidas_pkg::CHAR_MINUS)) |-> !rsp_last_char, "minus marked as last")
endmodule
`default_nettype wire

@@ dv/tb_signed_int_to_decimal_ascii_unit.sv @@
// self-checking testbench for signed_int_to_decimal_ascii_unit: drives signed integers,
// predicts the decimal ascii text of each one and checks every character that comes out
// depends on sidas_pkg and the unit's rtl, nothing else
`timescale 1ns / 1ps

// keeps the expected characters of every accepted number and checks results in order
class decimal_text_board;
   sidas_pkg::char_type text_q[$];
   int mismatches;
   int numbers;
   int chars_seen;
   int negatives;
   int longest;

   // spell one accepted number into its expected characters
   function void note_value(input logic [sidas_pkg::VALUE_BITS-1:0] value);
      logic [sidas_pkg::VALUE_BITS-1:0] mag;
      logic [3:0] digits[$];
      sidas_pkg::char_type c;
      int i;
      int run_len;
      numbers++;
      mag = value;
      run_len = 0;
      if (value[sidas_pkg::VALUE_BITS-1]) begin
         // unsigned negate, so the most negative value keeps its full magnitude
         mag = -value;
         negatives++;
         c.char_code = sidas_pkg::CHAR_MINUS;
         c.last_char = 1'b0;
         text_q.push_back(c);
         run_len++;
      end
      if (mag == 0) begin
         digits.push_front(4'd0);
      end
      while (mag != 0) begin
         digits.push_front(4'(mag % sidas_pkg::VALUE_BITS'(sidas_pkg::DIGIT_BASE)));
         mag = mag / sidas_pkg::VALUE_BITS'(sidas_pkg::DIGIT_BASE);
      end
      for (i = 0; i < digits.size(); i++) begin
         c.char_code = sidas_pkg::CHAR_ZERO + 8'(digits[i]);
         c.last_char = (i == digits.size() - 1);
         text_q.push_back(c);
         run_len++;
      end
      if (run_len > longest) begin
         longest = run_len;
      end
   endfunction

   // compare one accepted character with the oldest expectation
   function void check_char(input logic [7:0] code, input logic last);
      sidas_pkg::char_type want;
      chars_seen++;
      if (text_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: unexpected character %0d last %0b, nothing pending",
                     $time, code, last);
         end
      end else begin
         want = text_q.pop_front();
         if (want.char_code !== code || want.last_char !== last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch: expected char %0d last %0b, got char %0d last %0b",
                        $time, want.char_code, want.last_char, code, last);
            end
         end
      end
   endfunction

   function int depth();
      return text_q.size();
   endfunction
endclass

module tb_signed_int_to_decimal_ascii_unit;
   localparam int VB          = sidas_pkg::VALUE_BITS;
   // generous bound: several times the slowest legal run with long gaps and stalls
   localparam int CYCLE_LIMIT = 2_000_000;
   // idle wait after the final drain, before the summary
   localparam int SETTLE      = 60;
   localparam int RANDOM_ITEMS = 500;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [VB-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_char_code;
   logic                 rsp_last_char;

   decimal_text_board book = new;
   int unsigned cycles = 0;

   signed_int_to_decimal_ascii_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters still pending",
                  cycles, book.depth());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // random number: a quarter uniform over all bits, the rest spread over digit counts
   function automatic logic signed [VB-1:0] pick_value();
      longint lo;
      longint hi;
      longint m;
      int ndig;
      int k;
      if ($urandom_range(0, 3) == 0) begin
         return $urandom;
      end
      ndig = $urandom_range(1, 10);
      hi = 1;
      for (k = 0; k < ndig; k++) begin
         hi = hi * 10;
      end
      lo = (ndig == 1) ? 0 : hi / 10;
      hi = hi - 1;
      if (hi > 64'sd2147483647) begin
         hi = 64'sd2147483647;
      end
      m = lo + (longint'($urandom) % (hi - lo + 1));
      if ($urandom_range(0, 1) == 1) begin
         m = -m;
      end
      return VB'(m);
   endfunction

   // offer one number, hold it steady until the unit takes it
   task automatic send_value(input logic signed [VB-1:0] v, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do begin
         @(posedge clock);
      end while (req_stall);
      book.note_value(v);
   endtask

   // stop offering and let every pending character come out
   task automatic drain_text();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (book.depth() != 0);
   endtask

   // result side: stall bursts of random length, with rare long calm stretches
   initial begin
      int flow;
      int hold;
      forever begin
         flow = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
         rsp_stall <= 1'b0;
         repeat (flow) @(posedge clock);
         hold = idle_len();
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // every accepted character goes to the checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         book.check_char(rsp_char_code, rsp_last_char);
      end
   end

   initial begin
      logic signed [VB-1:0] edge_values[$];
      int n;
      int gap;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, single digits, powers of ten, both extremes, all-nines digits, alternating bits
      edge_values = '{
         32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
         32'sd99, 32'sd100, -32'sd100, 32'sd999999999, -32'sd999999999,
         32'sd1000000000, -32'sd1000000000, 32'sd1234567890, -32'sd1234567890,
         32'sd2147483647, -32'sd2147483647, 32'h8000_0000, 32'sd5, 32'h5555_5555,
         32'hAAAA_AAAA
      };
      foreach (edge_values[n]) begin
         send_value(edge_values[n], idle_len());
      end

      // hold off until the unit has said everything, then restart from idle
      drain_text();

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         // back-to-back stretch with no sender idling
         gap = (n >= 200 && n < 280) ? 0 : idle_len();
         send_value(pick_value(), gap);
         if (n % 125 == 124) begin
            drain_text();
         end
      end

      drain_text();
      repeat (SETTLE) @(posedge clock);

      $display("converted %0d numbers (%0d negative), checked %0d characters",
               book.numbers, book.negatives, book.chars_seen);
      $display("longest text %0d characters, %0d mismatches, %0d left unanswered",
               book.longest, book.mismatches, book.depth());
      if (book.mismatches == 0 && book.depth() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
